/* design/i2cms_pkg.sv */
// Shared types and constants for the I2C master byte sequencer.
// No dependencies; the engine and the top level import this package.
package i2cms_pkg;

    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

    localparam int unsigned PHASE_W = 10;
    localparam int unsigned STEP_W  = 5;

    localparam logic [STEP_W-1:0] STEPS_START  = 5'd4;
    localparam logic [STEP_W-1:0] STEPS_STOP   = 5'd3;
    localparam logic [STEP_W-1:0] STEPS_BYTE   = 5'd27;
    localparam logic [STEP_W-1:0] STEP_ACK_SDA = 5'd24;
    localparam logic [STEP_W-1:0] STEP_ACK_SCL = 5'd25;

    localparam logic [PHASE_W-1:0] PHASE_RESET = 10'd3;

    // Position of a step within one bit slot of a byte command.
    localparam logic [1:0] PH_DATA = 2'd0;
    localparam logic [1:0] PH_RISE = 2'd1;
    localparam logic [1:0] PH_FALL = 2'd2;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
    } t_res;

    localparam t_res RES_RESET = '{
        scl_level:   1'b1,
        sda_release: 1'b1,
        busy_res:    1'b0,
        done_res:    1'b0,
        rx_byte:     8'd0,
        ack_seen:    1'b1
    };

endpackage

/* design/i2cms_in_if.sv */
// Command channel of the I2C master byte sequencer: one word per bus tick.
// Standalone interface, no package needed.
interface i2cms_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic       ack_to_send;
    logic       sda_in;

    modport source (output valid, kind, tx_byte, ack_to_send, sda_in, input ready);
    modport sink   (input valid, kind, tx_byte, ack_to_send, sda_in, output ready);
endinterface

/* design/i2cms_out_if.sv */
// Result channel of the I2C master byte sequencer: pin levels and status.
// Standalone interface, no package needed.
interface i2cms_out_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;

    modport source (output valid, scl_level, sda_release, busy_res, done_res, rx_byte,
                    ack_seen, input ready);
    modport sink   (input valid, scl_level, sda_release, busy_res, done_res, rx_byte,
                    ack_seen, output ready);
endinterface

/* design/i2cms_engine.sv */
// Step sequencer of the I2C master: command state, hold counter and pin registers.
// Depends on i2cms_pkg; advanced by one tick whenever i_adv is high.
module i2cms_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic [i2cms_pkg::PHASE_W-1:0]  i_phase_ticks,
    input  i2cms_pkg::t_item               i_item,
    output i2cms_pkg::t_res                o_res
);
    import i2cms_pkg::*;

    t_cmd               r_cmd,   n_cmd;
    logic [STEP_W-1:0]  r_step,  n_step;
    logic [1:0]         r_ph,    n_ph;
    logic [PHASE_W-1:0] r_hold,  n_hold;
    logic [7:0]         r_shift, n_shift;
    logic               r_ack_choice, n_ack_choice;
    logic               r_scl,   n_scl;
    logic               r_sda,   n_sda;
    logic [7:0]         r_last_rx, n_last_rx;
    logic               r_last_ack, n_last_ack;

    logic [PHASE_W-1:0] hold_len;
    logic [PHASE_W-1:0] hold_dec;
    logic [STEP_W-1:0]  step_inc;
    logic [STEP_W-1:0]  step_total;
    logic               do_apply;
    logic               done;

    always_comb begin
        hold_len = (i_phase_ticks == '0) ? PHASE_W'(1) : i_phase_ticks;
        hold_dec = (r_hold != '0) ? r_hold - PHASE_W'(1) : '0;
        step_inc = r_step + STEP_W'(1);
        case (r_cmd)
            CMD_START: step_total = STEPS_START;
            CMD_STOP:  step_total = STEPS_STOP;
            default:   step_total = STEPS_BYTE;
        endcase

        n_cmd        = r_cmd;
        n_step       = r_step;
        n_ph         = r_ph;
        n_hold       = r_hold;
        n_shift      = r_shift;
        n_ack_choice = r_ack_choice;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_last_rx    = r_last_rx;
        n_last_ack   = r_last_ack;
        do_apply     = 1'b0;
        done         = 1'b0;

        if (r_cmd != CMD_IDLE) begin
            n_hold = hold_dec;
            if (hold_dec == '0) begin
                if (step_inc >= step_total) begin
                    if (r_cmd == CMD_READ) begin
                        n_sda     = 1'b1;
                        n_last_rx = r_shift;
                    end
                    n_cmd  = CMD_IDLE;
                    n_step = '0;
                    n_ph   = PH_DATA;
                    done   = 1'b1;
                end else begin
                    n_step   = step_inc;
                    n_ph     = (r_ph == PH_FALL) ? PH_DATA : r_ph + 2'd1;
                    do_apply = 1'b1;
                end
            end
        end else if (i_item.kind inside {[CMD_START:CMD_READ]}) begin
            n_cmd        = t_cmd'(i_item.kind);
            n_step       = '0;
            n_ph         = PH_DATA;
            n_shift      = (i_item.kind == CMD_WRITE) ? i_item.tx_byte : 8'd0;
            n_ack_choice = i_item.ack_to_send;
            do_apply     = 1'b1;
        end

        // Apply the pin change of the step just entered, then restart the hold.
        if (do_apply) begin
            n_hold = hold_len;
            case (n_cmd)
                CMD_START: begin
                    case (n_step[1:0])
                        2'd0:    n_sda = 1'b1;
                        2'd1:    n_scl = 1'b1;
                        2'd2:    n_sda = 1'b0;
                        default: n_scl = 1'b0;
                    endcase
                end
                CMD_STOP: begin
                    case (n_step[1:0])
                        2'd0:    n_sda = 1'b0;
                        2'd1:    n_scl = 1'b1;
                        default: n_sda = 1'b1;
                    endcase
                end
                CMD_WRITE: begin
                    if (n_step < STEP_ACK_SDA) begin
                        case (n_ph)
                            PH_DATA: begin
                                n_sda   = n_shift[7];
                                n_shift = {n_shift[6:0], 1'b0};
                            end
                            PH_RISE: n_scl = 1'b1;
                            default: n_scl = 1'b0;
                        endcase
                    end else if (n_step == STEP_ACK_SDA) begin
                        n_sda = 1'b1;
                    end else if (n_step == STEP_ACK_SCL) begin
                        n_scl = 1'b1;
                    end else begin
                        n_last_ack = i_item.sda_in;
                        n_scl      = 1'b0;
                    end
                end
                default: begin
                    if (n_step < STEP_ACK_SDA) begin
                        case (n_ph)
                            PH_DATA: begin
                                if (n_step == '0) begin
                                    n_sda = 1'b1;
                                end
                            end
                            PH_RISE: n_scl = 1'b1;
                            default: begin
                                n_shift = {n_shift[6:0], i_item.sda_in};
                                n_scl   = 1'b0;
                            end
                        endcase
                    end else if (n_step == STEP_ACK_SDA) begin
                        n_sda = !n_ack_choice;
                    end else if (n_step == STEP_ACK_SCL) begin
                        n_scl = 1'b1;
                    end else begin
                        n_scl = 1'b0;
                    end
                end
            endcase
        end

        o_res.scl_level   = n_scl;
        o_res.sda_release = n_sda;
        o_res.busy_res    = (n_cmd != CMD_IDLE);
        o_res.done_res    = done;
        o_res.rx_byte     = n_last_rx;
        o_res.ack_seen    = n_last_ack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd        <= CMD_IDLE;
            r_step       <= '0;
            r_ph         <= PH_DATA;
            r_hold       <= '0;
            r_shift      <= '0;
            r_ack_choice <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_last_rx    <= '0;
            r_last_ack   <= 1'b1;
        end else if (i_adv) begin
            r_cmd        <= n_cmd;
            r_step       <= n_step;
            r_ph         <= n_ph;
            r_hold       <= n_hold;
            r_shift      <= n_shift;
            r_ack_choice <= n_ack_choice;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_last_rx    <= n_last_rx;
            r_last_ack   <= n_last_ack;
        end
    end

endmodule

/* design/i2c_master_byte_sequencer.sv */
// Top level of the I2C master byte sequencer: handshake, phase register, result register.
// Depends on i2cms_pkg, i2cms_in_if, i2cms_out_if and i2cms_engine.
//
// Each input word is one bus tick and produces exactly one result word. A word is
// taken in every cycle while the result register is empty or being drained, so the
// sustained rate is one word per clock; the result is registered in the cycle after the
// word is accepted, with the combinational step logic in the engine feeding the result
// register. The result holds the SCL and SDA levels to drive, busy and done status,
// the last received byte and the last acknowledge seen. phase_ticks (reset 3, zero
// acts as one) sets how many ticks each pin level is held and should only be written
// while no command is running.
module i2c_master_byte_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    i2cms_in_if.sink                      i_cmd,
    i2cms_out_if.source                   o_res,
    input  logic                          i_cfg_we,
    input  logic [i2cms_pkg::PHASE_W-1:0] i_cfg_wdata
);
    import i2cms_pkg::*;

    logic [PHASE_W-1:0] r_phase_ticks;
    logic               r_out_valid, n_out_valid;
    t_res               r_res;
    t_res               step_res;
    t_item              item;
    logic               accept;

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;

    assign item.kind        = i_cmd.kind;
    assign item.tx_byte     = i_cmd.tx_byte;
    assign item.ack_to_send = i_cmd.ack_to_send;
    assign item.sda_in      = i_cmd.sda_in;

    i2cms_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (accept),
        .i_phase_ticks (r_phase_ticks),
        .i_item        (item),
        .o_res         (step_res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_RESET;
            r_out_valid   <= 1'b0;
            r_res         <= RES_RESET;
        end else begin
            if (i_cfg_we) begin
                r_phase_ticks <= i_cfg_wdata;
            end
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_res <= step_res;
            end
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.scl_level   = r_res.scl_level;
    assign o_res.sda_release = r_res.sda_release;
    assign o_res.busy_res    = r_res.busy_res;
    assign o_res.done_res    = r_res.done_res;
    assign o_res.rx_byte     = r_res.rx_byte;
    assign o_res.ack_seen    = r_res.ack_seen;

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res.done_res |-> !r_res.busy_res)
        else $error("done reported while still busy");

    a_start_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !r_res.busy_res && (i_cmd.kind >= CMD_START) && (i_cmd.kind <= CMD_READ)
        |=> r_res.busy_res)
        else $error("valid command from idle did not make the sequencer busy");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_cmd.ready)
        else $error("input stalled while the result register is empty");
`endif

endmodule
